// ===== rtl/sha256_message_hash_defines.svh =====
// assertion macros for the sha-256 message hash checker
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef SHA256_MESSAGE_HASH_DEFINES_SVH
`define SHA256_MESSAGE_HASH_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SHA_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SHA_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/sha256_pkg.sv =====
// shared types, constants and round functions of the sha-256 message hash
// no dependencies
package sha256_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 64;
  localparam int unsigned RoundW = $clog2(Rounds);
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned FillW  = $clog2(BlockBytes);
  localparam int unsigned CountW = 61;
  localparam int unsigned DigestWords = 8;
  localparam int unsigned IdxW   = $clog2(DigestWords);

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [FillW-1:0] LenStart = FillW'(56);
  localparam logic [FillW-1:0] FillLast = FillW'(BlockBytes - 1);
  localparam logic [RoundW-1:0] RoundLast = RoundW'(Rounds - 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(DigestWords - 1);

  localparam logic [WordW-1:0] IvTab [DigestWords] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [WordW-1:0] KTab [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // input and result items
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic [IdxW-1:0]  word_index;
    logic             last_word;
  } out_item_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_e;

  // source of the byte shifted into the block window
  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_e;

  typedef struct packed {
    logic      shift_en;
    byte_sel_e sel;
    logic      count_inc;
    logic      load_vars;
    logic      round_en;
    logic      final_add;
    logic      emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [FillW-1:0] fill;
    logic             round_last;
    logic             out_busy;
  } dp_stat_t;

  // sha-256 sigma functions
  function automatic logic [WordW-1:0] big_sig0(input logic [WordW-1:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WordW-1:0] big_sig1(input logic [WordW-1:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WordW-1:0] sml_sig0(input logic [WordW-1:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WordW-1:0] sml_sig1(input logic [WordW-1:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== rtl/sha256_message_hash.sv =====
// top level of the sha-256 message hash: controller and datapath
// depends on sha256_pkg, sha256_ctrl, sha256_dp
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (one message byte)
//  out     | output    | out_valid_o / out_ready_i | out_data_o (one digest word)
//
// a message byte is one transfer per cycle while the input is ready; every 64th byte adds a
// compression (load, 64 rounds on the single round unit, chaining add)
// the end of a message costs the padding bytes up to the block end, one or two
// compressions and the hand-over of the digest to the output register
// input is stalled during padding and compression; a stalled output only holds back the
// hand-over of the next digest, bytes of the next message keep flowing meanwhile
// reset brings the chaining words to the initial hash and clears all counters
module sha256_message_hash (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sha256_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sha256_pkg::out_item_t out_data_o
);
  import sha256_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha256_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sha256_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (in_data_i.data_byte),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/sha256_ctrl.sv =====
// sequencer of the sha-256 message hash: byte intake, padding, rounds, digest hand-over
// depends on sha256_pkg
module sha256_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sha256_pkg::in_item_t in_data_i,
  input  sha256_pkg::dp_stat_t stat_i,
  output sha256_pkg::dp_cmd_t  cmd_o
);
  import sha256_pkg::*;

  state_e state_q, state_d;
  logic   last_q, last_d;       // message ended, padding still to do
  logic   mark_q, mark_d;       // 0x80 marker written
  logic   lenok_q, lenok_d;     // this block takes the length field
  logic   lendone_q, lendone_d; // length field complete
  logic   accept;
  logic   fill_end;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign fill_end   = (stat_i.fill == FillLast);

  // next state and padding flags
  always_comb begin
    state_d   = state_q;
    last_d    = last_q;
    mark_d    = mark_q;
    lenok_d   = lenok_q;
    lendone_d = lendone_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.last_byte) begin
            last_d    = 1'b1;
            mark_d    = 1'b0;
            lenok_d   = 1'b0;
            lendone_d = 1'b0;
          end
          if (in_data_i.byte_valid && fill_end) begin
            state_d = ST_LOAD;
          end else if (in_data_i.last_byte) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (!mark_q) begin
          mark_d  = 1'b1;
          lenok_d = (stat_i.fill < LenStart);
        end else if (lenok_q && fill_end) begin
          lendone_d = 1'b1;
        end
        if (fill_end) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (stat_i.round_last) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (lendone_q) begin
          state_d = ST_EMIT;
        end else begin
          // the next block carries the length, after the marker if it is still due
          lenok_d = 1'b1;
          state_d = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (!stat_i.out_busy) begin
          last_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    cmd_o.sel = SEL_MSG;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.shift_en  = accept && in_data_i.byte_valid;
        cmd_o.count_inc = accept && in_data_i.byte_valid;
      end
      ST_PAD: begin
        cmd_o.shift_en = 1'b1;
        if (!mark_q) begin
          cmd_o.sel = SEL_MARK;
        end else if (lenok_q && (stat_i.fill >= LenStart)) begin
          cmd_o.sel = SEL_LEN;
        end else begin
          cmd_o.sel = SEL_ZERO;
        end
      end
      ST_LOAD:  cmd_o.load_vars = 1'b1;
      ST_ROUND: cmd_o.round_en  = 1'b1;
      ST_FINAL: cmd_o.final_add = 1'b1;
      ST_EMIT:  cmd_o.emit      = !stat_i.out_busy;
      default:  cmd_o = '0;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      last_q    <= 1'b0;
      mark_q    <= 1'b0;
      lenok_q   <= 1'b0;
      lendone_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      last_q    <= last_d;
      mark_q    <= mark_d;
      lenok_q   <= lenok_d;
      lendone_q <= lendone_d;
    end
  end

endmodule

// ===== rtl/sha256_dp.sv =====
// datapath of the sha-256 message hash: block window, round logic, chaining words,
// byte count and digest output register; depends on sha256_pkg
module sha256_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            in_byte_i,
  input  sha256_pkg::dp_cmd_t   cmd_i,
  output sha256_pkg::dp_stat_t  stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sha256_pkg::out_item_t out_data_o
);
  import sha256_pkg::*;

  localparam int unsigned WinW = BlockBytes * 8;
  localparam int unsigned DigW = DigestWords * WordW;

  logic [WinW-1:0]        win_q;      // block bytes, then the rolling schedule
  logic [WordW-1:0]       h_q [DigestWords];
  logic [WordW-1:0]       v_q [DigestWords];
  logic [CountW-1:0]      count_q;
  logic [FillW-1:0]       fill_q;
  logic [RoundW-1:0]      round_q;
  logic [DigW-1:0]        dig_q;
  logic [IdxW-1:0]        idx_q;
  logic                   busy_q;

  logic [63:0]            len_bits;
  logic [7:0]             shift_byte;
  logic [WordW-1:0]       w0, w1, w9, w14, w_new;
  logic [WordW-1:0]       t1, t2, ch, maj;
  logic                   out_xfer;

  // byte fed into the window
  assign len_bits = {count_q, 3'b000};
  always_comb begin
    unique case (cmd_i.sel)
      SEL_MSG:  shift_byte = in_byte_i;
      SEL_MARK: shift_byte = PadMark;
      SEL_ZERO: shift_byte = 8'h00;
      SEL_LEN:  shift_byte = len_bits[{~fill_q[2:0], 3'b000} +: 8];
      default:  shift_byte = 8'h00;
    endcase
  end

  // message schedule: word 0 is the current round word
  assign w0    = win_q[WinW-1 -: WordW];
  assign w1    = win_q[WinW-1-WordW -: WordW];
  assign w9    = win_q[WinW-1-9*WordW -: WordW];
  assign w14   = win_q[WinW-1-14*WordW -: WordW];
  assign w_new = w0 + sml_sig0(w1) + w9 + sml_sig1(w14);

  // one compression round
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + big_sig1(v_q[4]) + ch + KTab[round_q] + w0;
  assign t2  = big_sig0(v_q[0]) + maj;

  assign out_xfer = busy_q && out_ready_i;

  // window, working variables and digest words
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_en) begin
      win_q <= {win_q[WinW-9:0], shift_byte};
    end else if (cmd_i.round_en) begin
      win_q <= {win_q[WinW-WordW-1:0], w_new};
    end
    if (cmd_i.load_vars) begin
      v_q <= h_q;
    end else if (cmd_i.round_en) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (cmd_i.emit) begin
      dig_q <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
    end else if (out_xfer) begin
      dig_q <= {dig_q[DigW-WordW-1:0], {WordW{1'b0}}};
    end
  end

  // chaining words, counters and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q     <= IvTab;
      count_q <= '0;
      fill_q  <= '0;
      round_q <= '0;
      idx_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      if (cmd_i.final_add) begin
        for (int i = 0; i < DigestWords; i++) begin
          h_q[i] <= h_q[i] + v_q[i];
        end
      end else if (cmd_i.emit) begin
        h_q <= IvTab;
      end
      if (cmd_i.emit) begin
        count_q <= '0;
      end else if (cmd_i.count_inc) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.shift_en) begin
        fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.round_en) begin
        round_q <= round_q + 1'b1;
      end
      if (cmd_i.emit) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (out_xfer) begin
        busy_q <= (idx_q != IdxLast);
        idx_q  <= idx_q + 1'b1;
      end
    end
  end

  assign stat_o.fill       = fill_q;
  assign stat_o.round_last = (round_q == RoundLast);
  assign stat_o.out_busy   = busy_q;

  assign out_valid_o            = busy_q;
  assign out_data_o.digest_word = dig_q[DigW-1 -: WordW];
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.last_word   = (idx_q == IdxLast);

endmodule

// ===== rtl/sha256_checker.sv =====
// port-level checks of the sha-256 message hash, bound to the top level
// depends on sha256_pkg and sha256_message_hash_defines.svh
`include "sha256_message_hash_defines.svh"

module sha256_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input sha256_pkg::in_item_t  in_data_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input sha256_pkg::out_item_t out_data_o
);
  import sha256_pkg::*;

  // a stalled digest word holds
  `SHA_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "digest word changed while stalled")

  // digest words leave in order
  `SHA_ASSERT_NXT(a_idx_step, out_valid_o && out_ready_i && !out_data_o.last_word, out_valid_o && (out_data_o.word_index == $past(out_data_o.word_index) + 1'b1), "digest word order broken")

  // a digest always starts at word zero
  `SHA_ASSERT_IMP(a_idx_start, $rose(out_valid_o), out_data_o.word_index == '0, "digest did not start at word zero")

  // the digest ends with a gap
  `SHA_ASSERT_NXT(a_out_gap, out_valid_o && out_ready_i && out_data_o.last_word, !out_valid_o, "digest word after the last one")

  // end of message stops intake for padding or compression
  `SHA_ASSERT_NXT(a_last_stall, in_valid_i && in_ready_o && in_data_i.last_byte, !in_ready_o, "input taken right after message end")

endmodule

bind sha256_message_hash sha256_checker u_checker (.*);
